// ----- design/wpd_pkg.sv -----
// Shared widths, constants and types for the weighted pose distance block.
// No dependencies; every other design file refers to this package by scope.
`default_nettype none

package wpd_pkg;

    localparam int COORD_W   = 24;
    localparam int MAG_W     = 24;
    localparam int SQ_W      = 48;
    localparam int RAD_W     = 50;
    localparam int ROOT_W    = 25;
    localparam int REM_W     = 26;
    localparam int WEIGHT_W  = 16;
    localparam int PROD_W    = 41;
    localparam int FRAC_W    = 12;
    localparam int TERM_W    = 29;
    localparam int COST_W    = 34;
    localparam int NODE_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W     = 5;
    localparam int SQ_STEPS  = 24;
    localparam int RT_STEPS  = 25;
    localparam int AXES      = 3;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'd4096;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

endpackage

`default_nettype wire

// ----- design/wpd_square.sv -----
// Bit-serial sum of squares of the three coordinate differences of two points.
// Three shift-and-add lanes run in parallel, one multiplier bit per cycle.
// Depends on wpd_pkg.
`default_nettype none

module wpd_square (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  wpd_pkg::point_t          first_pt,
    input  wpd_pkg::point_t          second_pt,
    output logic                     done,
    output logic [wpd_pkg::RAD_W-1:0] sum
);

    logic [wpd_pkg::AXES-1:0][wpd_pkg::COORD_W-1:0] first_ax;
    logic [wpd_pkg::AXES-1:0][wpd_pkg::COORD_W-1:0] second_ax;
    logic [wpd_pkg::AXES-1:0][wpd_pkg::MAG_W-1:0]   mag_in;

    logic [wpd_pkg::AXES-1:0][wpd_pkg::MAG_W-1:0]   mag_reg;
    logic [wpd_pkg::AXES-1:0][wpd_pkg::MAG_W-1:0]   bits_reg;
    logic [wpd_pkg::AXES-1:0][wpd_pkg::MAG_W-1:0]   bits_next;
    logic [wpd_pkg::AXES-1:0][wpd_pkg::SQ_W-1:0]    acc_reg;
    logic [wpd_pkg::AXES-1:0][wpd_pkg::SQ_W-1:0]    acc_next;
    logic [wpd_pkg::RAD_W-1:0]                      sum_reg;
    logic [wpd_pkg::RAD_W-1:0]                      sum_next;
    logic [wpd_pkg::CNT_W-1:0]                      cnt_reg;
    logic                                           busy_reg;
    logic                                           done_reg;

    assign first_ax  = {first_pt.x, first_pt.y, first_pt.z};
    assign second_ax = {second_pt.x, second_pt.y, second_pt.z};

    always_comb begin
        logic [wpd_pkg::COORD_W:0] diff;
        for (int i = 0; i < wpd_pkg::AXES; i++) begin
            diff = {first_ax[i][wpd_pkg::COORD_W-1], first_ax[i]}
                 - {second_ax[i][wpd_pkg::COORD_W-1], second_ax[i]};
            mag_in[i] = diff[wpd_pkg::COORD_W] ? wpd_pkg::MAG_W'(-diff)
                                               : wpd_pkg::MAG_W'(diff);
        end
    end

    always_comb begin
        for (int i = 0; i < wpd_pkg::AXES; i++) begin
            acc_next[i] = {acc_reg[i][wpd_pkg::SQ_W-2:0], 1'b0}
                        + (bits_reg[i][wpd_pkg::MAG_W-1]
                           ? {{(wpd_pkg::SQ_W-wpd_pkg::MAG_W){1'b0}}, mag_reg[i]}
                           : {wpd_pkg::SQ_W{1'b0}});
            bits_next[i] = {bits_reg[i][wpd_pkg::MAG_W-2:0], 1'b0};
        end
        sum_next = {2'b00, acc_reg[0]} + {2'b00, acc_reg[1]} + {2'b00, acc_reg[2]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= wpd_pkg::CNT_W'(wpd_pkg::SQ_STEPS);
            end else if (busy_reg) begin
                if (cnt_reg != '0) begin
                    cnt_reg <= cnt_reg - 1'b1;
                end else begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mag_reg  <= mag_in;
            bits_reg <= mag_in;
            acc_reg  <= '0;
        end else if (busy_reg && cnt_reg != '0) begin
            acc_reg  <= acc_next;
            bits_reg <= bits_next;
        end
        if (busy_reg && cnt_reg == '0) begin
            sum_reg <= sum_next;
        end
    end

    assign done = done_reg;
    assign sum  = sum_reg;

endmodule

`default_nettype wire

// ----- design/wpd_root.sv -----
// Bit-serial integer square root, rounded down, with the weight product formed
// alongside: each root bit also shifts and adds the weight. Depends on wpd_pkg.
`default_nettype none

module wpd_root (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [wpd_pkg::RAD_W-1:0]    radicand,
    input  logic [wpd_pkg::WEIGHT_W-1:0] weight,
    output logic                         done,
    output logic [wpd_pkg::PROD_W-1:0]   prod
);

    logic [wpd_pkg::RAD_W-1:0]    rad_reg;
    logic [wpd_pkg::REM_W-1:0]    rem_reg;
    logic [wpd_pkg::REM_W-1:0]    rem_next;
    logic [wpd_pkg::ROOT_W-1:0]   root_reg;
    logic [wpd_pkg::ROOT_W-1:0]   root_next;
    logic [wpd_pkg::PROD_W-1:0]   prod_reg;
    logic [wpd_pkg::PROD_W-1:0]   prod_next;
    logic [wpd_pkg::WEIGHT_W-1:0] weight_reg;
    logic [wpd_pkg::CNT_W-1:0]    cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;

    logic [wpd_pkg::REM_W+1:0]    rem_sh;
    logic [wpd_pkg::REM_W+2:0]    trial;
    logic                         take;

    always_comb begin
        rem_sh    = {rem_reg, rad_reg[wpd_pkg::RAD_W-1 -: 2]};
        trial     = {1'b0, rem_sh} - {2'b00, root_reg, 2'b01};
        take      = !trial[wpd_pkg::REM_W+2];
        rem_next  = take ? trial[wpd_pkg::REM_W-1:0] : rem_sh[wpd_pkg::REM_W-1:0];
        root_next = {root_reg[wpd_pkg::ROOT_W-2:0], take};
        prod_next = {prod_reg[wpd_pkg::PROD_W-2:0], 1'b0}
                  + (take ? {{(wpd_pkg::PROD_W-wpd_pkg::WEIGHT_W){1'b0}}, weight_reg}
                          : {wpd_pkg::PROD_W{1'b0}});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= wpd_pkg::CNT_W'(wpd_pkg::RT_STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == wpd_pkg::CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg    <= radicand;
            rem_reg    <= '0;
            root_reg   <= '0;
            prod_reg   <= '0;
            weight_reg <= weight;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[wpd_pkg::RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
            prod_reg <= prod_next;
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

`default_nettype wire

// ----- design/weighted_pose_distance_top.sv -----
// Weighted pose distance: top level with weight registers, sequencer and cost
// accumulator. Depends on wpd_pkg, wpd_square and wpd_root.
//
// Each input transaction carries one body node in two poses. The block squares
// the three coordinate differences bit-serially and registers their sum, takes
// the integer square root one bit per cycle while multiplying it by the node
// weight, then adds the truncated term to a saturating 34-bit accumulator. An
// item passes through the square unit, the root unit and the accumulate state in
// turn before the next is accepted; s_ready is high only between items. On an
// item with s_last set the accumulated cost is loaded into the output register
// and the accumulator clears. The output register holds its transaction until
// m_ready; the next item is accepted meanwhile, and only a second result waits
// for the register to free up.
// Weights are written through cfg_we/cfg_index/cfg_data; the user must write
// them only while idle, as the block itself does not enforce it. Writes to
// indexes without a node are dropped. Synchronous reset sets all weights to 1.0,
// clears the accumulator and drops any pending result.
`default_nettype none

module weighted_pose_distance_top #(
    parameter int NODES = 5
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [wpd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wpd_pkg::WEIGHT_W-1:0]        cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [wpd_pkg::NODE_W-1:0]          s_node,
    input  logic signed [wpd_pkg::COORD_W-1:0]  s_first_x,
    input  logic signed [wpd_pkg::COORD_W-1:0]  s_first_y,
    input  logic signed [wpd_pkg::COORD_W-1:0]  s_first_z,
    input  logic signed [wpd_pkg::COORD_W-1:0]  s_second_x,
    input  logic signed [wpd_pkg::COORD_W-1:0]  s_second_y,
    input  logic signed [wpd_pkg::COORD_W-1:0]  s_second_z,
    input  logic                                s_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [wpd_pkg::COST_W-1:0]          m_cost
);

    localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam logic [wpd_pkg::NODE_W:0] NODE_LIMIT = (wpd_pkg::NODE_W+1)'(NODES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQ   = 2'd1;
    localparam logic [1:0] ST_RT   = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]                    state_reg;
    logic [1:0]                    state_next;
    logic [wpd_pkg::WEIGHT_W-1:0]  weight_reg [NODES];
    logic [wpd_pkg::WEIGHT_W-1:0]  wsel_reg;
    logic                          last_reg;
    logic [wpd_pkg::COST_W-1:0]    acc_reg;
    logic [wpd_pkg::COST_W-1:0]    m_cost_reg;
    logic                          m_valid_reg;

    logic                          s_accept;
    logic                          node_ok;
    logic                          cfg_ok;
    logic                          out_free;
    logic                          sq_done;
    logic [wpd_pkg::RAD_W-1:0]     sq_sum;
    logic                          rt_done;
    logic [wpd_pkg::PROD_W-1:0]    rt_prod;
    logic [wpd_pkg::TERM_W-1:0]    term;
    logic [wpd_pkg::COST_W:0]      cost_sum;
    logic [wpd_pkg::COST_W-1:0]    cost_sat;
    wpd_pkg::point_t               first_pt;
    wpd_pkg::point_t               second_pt;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign node_ok  = ({1'b0, s_node} < NODE_LIMIT);
    assign cfg_ok   = ({1'b0, cfg_index} < NODE_LIMIT);
    assign out_free = !m_valid_reg || m_ready;

    assign first_pt  = '{x: s_first_x, y: s_first_y, z: s_first_z};
    assign second_pt = '{x: s_second_x, y: s_second_y, z: s_second_z};

    wpd_square u_square (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_accept),
        .first_pt  (first_pt),
        .second_pt (second_pt),
        .done      (sq_done),
        .sum       (sq_sum)
    );

    wpd_root u_root (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_done),
        .radicand (sq_sum),
        .weight   (wsel_reg),
        .done     (rt_done),
        .prod     (rt_prod)
    );

    always_comb begin
        term     = rt_prod[wpd_pkg::PROD_W-1:wpd_pkg::FRAC_W];
        cost_sum = {1'b0, acc_reg}
                 + {{(wpd_pkg::COST_W+1-wpd_pkg::TERM_W){1'b0}}, term};
        cost_sat = cost_sum[wpd_pkg::COST_W] ? {wpd_pkg::COST_W{1'b1}}
                                             : cost_sum[wpd_pkg::COST_W-1:0];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) state_next = ST_SQ;
            end
            ST_SQ: begin
                if (sq_done) state_next = ST_RT;
            end
            ST_RT: begin
                if (rt_done) state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!last_reg || out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NODES; i++) begin
                weight_reg[i] <= wpd_pkg::WEIGHT_ONE;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_we && cfg_ok) begin
                weight_reg[cfg_index[IDX_W-1:0]] <= cfg_data;
            end
            if (state_reg == ST_FIN && last_reg && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_FIN) begin
                if (!last_reg) begin
                    acc_reg <= cost_sat;
                end else if (out_free) begin
                    acc_reg <= '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            wsel_reg <= node_ok ? weight_reg[s_node[IDX_W-1:0]] : '0;
            last_reg <= s_last;
        end
        if (state_reg == ST_FIN && last_reg && out_free) begin
            m_cost_reg <= cost_sat;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_cost  = m_cost_reg;

endmodule

`default_nettype wire
